// ===== sv/actr_pkg.sv =====
package actr_pkg;

  localparam int unsigned FinalRound = 14;
  localparam int unsigned QueueDepth = 2;

  localparam logic [2:0] RegKey0    = 3'd0;
  localparam logic [2:0] RegKey1    = 3'd1;
  localparam logic [2:0] RegKey2    = 3'd2;
  localparam logic [2:0] RegKey3    = 3'd3;
  localparam logic [2:0] RegNonce   = 3'd4;
  localparam logic [2:0] RegCtrInit = 3'd5;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ROUND,
    BK_EMIT
  } back_state_e;

  // One queued byte with its front-end classification.
  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       last;
    logic [3:0] pos;
    logic       need_block;
  } entry_t;

  typedef struct packed {
    logic [255:0] key;
    logic [63:0]  nonce;
    logic [63:0]  ctr_init;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] count;
  } front_status_t;

  typedef struct packed {
    logic busy;
    logic pop;
  } back_status_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte k of a state sits at [127-8k -: 8].
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8 * (r + 4 * c) -: 8] = SBOX[s[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8]];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0]   a0, a1, a2, a3, all;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0  = s[127 - 32 * c -: 8];
      a1  = s[119 - 32 * c -: 8];
      a2  = s[111 - 32 * c -: 8];
      a3  = s[103 - 32 * c -: 8];
      all = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 32 * c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      t[119 - 32 * c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      t[111 - 32 * c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      t[103 - 32 * c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // Next four schedule words from the previous eight (oldest in the top bits).
  function automatic logic [127:0] key_step(input logic [255:0] kw,
                                            input logic rot, input logic [7:0] rcon);
    logic [31:0] t, n0, n1, n2, n3;
    t  = kw[31:0];
    t  = rot ? (sub_word({t[23:0], t[31:24]}) ^ {rcon, 24'h000000}) : sub_word(t);
    n0 = kw[255:224] ^ t;
    n1 = kw[223:192] ^ n0;
    n2 = kw[191:160] ^ n1;
    n3 = kw[159:128] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

endpackage

// ===== sv/actr_front.sv =====
module actr_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [7:0]               data_byte_i,
  input  logic                     start_of_message_i,
  input  logic                     end_of_message_i,
  input  logic                     pop_i,
  output actr_pkg::entry_t         entry_o,
  output actr_pkg::front_status_t  status_o
);

  actr_pkg::entry_t mem_q [actr_pkg::QueueDepth];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic [3:0]       pos_q, pos_d;
  logic             push;
  logic [3:0]       pos_use;

  assign in_stall_o = (count_q == 2'(actr_pkg::QueueDepth));
  assign push       = in_valid_i && !in_stall_o;
  // A start restarts the block; position zero always needs a fresh block.
  assign pos_use    = start_of_message_i ? 4'd0 : pos_q;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    pos_d    = push ? pos_use + 4'd1 : pos_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
      pos_q    <= 4'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
      pos_q    <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{data: data_byte_i, start: start_of_message_i,
                           last: end_of_message_i, pos: pos_use,
                           need_block: (pos_use == 4'd0)};
    end
  end

  assign entry_o         = mem_q[rd_ptr_q];
  assign status_o.valid  = (count_q != 2'd0);
  assign status_o.count  = count_q;

endmodule

// ===== sv/actr_back.sv =====
module actr_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  actr_pkg::cfg_t         cfg_i,
  input  logic                   q_valid_i,
  input  actr_pkg::entry_t       entry_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [7:0]             out_byte_o,
  output logic                   last_out_o,
  output actr_pkg::back_status_t status_o
);

  actr_pkg::back_state_e state_q, state_d;

  logic [63:0]  ctr_q, ctr_d;
  logic [127:0] st_q, st_d;
  logic [255:0] kw_q, kw_d;
  logic [7:0]   rcon_q, rcon_d;
  logic [3:0]   rnd_q, rnd_d;
  logic [127:0] ks_q, ks_d;
  logic         out_valid_q;
  logic [7:0]   out_byte_q;
  logic         last_q;

  logic         slot_free;
  logic         last_round;
  logic         setup, step, emit;
  logic [63:0]  ctr_use;
  logic [127:0] st_sub, st_mix, ks_shift;

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign last_round = (rnd_q == 4'(actr_pkg::FinalRound));
  assign ctr_use    = entry_i.start ? cfg_i.ctr_init : ctr_q;
  assign st_sub     = actr_pkg::sub_shift(st_q);
  assign st_mix     = last_round ? st_sub : actr_pkg::mix_columns(st_sub);
  assign ks_shift   = ks_q << {entry_i.pos, 3'b000};

  always_comb begin
    state_d = state_q;
    case (state_q)
      actr_pkg::BK_IDLE: begin
        if (q_valid_i) begin
          state_d = entry_i.need_block ? actr_pkg::BK_ROUND : actr_pkg::BK_EMIT;
        end
      end
      actr_pkg::BK_ROUND: begin
        if (last_round) begin
          state_d = actr_pkg::BK_EMIT;
        end
      end
      actr_pkg::BK_EMIT: begin
        if (slot_free) begin
          state_d = actr_pkg::BK_IDLE;
        end
      end
      default: state_d = actr_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    setup = 1'b0;
    step  = 1'b0;
    emit  = 1'b0;
    case (state_q)
      actr_pkg::BK_IDLE:  setup = q_valid_i && entry_i.need_block;
      actr_pkg::BK_ROUND: step  = 1'b1;
      actr_pkg::BK_EMIT:  emit  = slot_free;
      default: begin
        setup = 1'b0;
      end
    endcase
  end

  always_comb begin
    ctr_d  = ctr_q;
    st_d   = st_q;
    kw_d   = kw_q;
    rcon_d = rcon_q;
    rnd_d  = rnd_q;
    ks_d   = ks_q;
    if (setup) begin
      ctr_d  = ctr_use;
      st_d   = {cfg_i.nonce, ctr_use} ^ cfg_i.key[255:128];
      kw_d   = cfg_i.key;
      rcon_d = 8'h01;
      rnd_d  = 4'd1;
    end else if (step) begin
      st_d  = st_mix ^ kw_q[127:0];
      kw_d  = {kw_q[127:0], actr_pkg::key_step(kw_q, rnd_q[0], rcon_q)};
      rnd_d = rnd_q + 4'd1;
      if (rnd_q[0]) begin
        rcon_d = actr_pkg::xtime(rcon_q);
      end
      if (last_round) begin
        ks_d  = st_mix ^ kw_q[127:0];
        ctr_d = ctr_q + 64'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= actr_pkg::BK_IDLE;
      ctr_q       <= '0;
      ks_q        <= '0;
      rnd_q       <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ctr_q   <= ctr_d;
      ks_q    <= ks_d;
      rnd_q   <= rnd_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    st_q   <= st_d;
    kw_q   <= kw_d;
    rcon_q <= rcon_d;
    if (emit) begin
      out_byte_q <= entry_i.data ^ ks_shift[127:120];
      last_q     <= entry_i.last;
    end
  end

  assign pop_o           = emit;
  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign last_out_o      = last_q;
  assign status_o.busy   = (state_q != actr_pkg::BK_IDLE);
  assign status_o.pop    = emit;

endmodule

// ===== sv/aes256_ctr_stream_cipher.sv =====
// AES-256 counter-mode byte cipher. Each input transaction carries one byte and
// gives one output transaction: the byte XORed with the keystream. A front end
// tracks the position in the 16-byte block and queues up to two bytes; a back
// end builds each keystream block, the AES-256 encryption of the nonce followed
// by the 64-bit block counter, with one cipher round per cycle and the key
// schedule run alongside. A byte that opens a block (position zero, or any byte
// flagged start of message) runs the round loop in the back end before it goes
// out; every other byte is fetched from the queue and loads the output register
// directly. The back end handles one byte at a time while the front end queues
// the next; the handling of each byte, the round loop and any output stall set
// the throughput.
// A start reloads the counter from counter_start; the counter then increments
// for each block produced and wraps at 2^64. Configuration writes (keys 0-3,
// nonce, counter start) are taken at any write enable; write only while idle.
module aes256_ctr_stream_cipher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        start_of_message_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        last_out_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  actr_pkg::cfg_t          cfg_q;
  actr_pkg::entry_t        entry;
  actr_pkg::front_status_t front_status;
  actr_pkg::back_status_t  back_status;
  logic                    pop;

  // Register file: hold each value until rewritten, drop unknown indexes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        actr_pkg::RegKey0:    cfg_q.key[255:192] <= cfg_data_i;
        actr_pkg::RegKey1:    cfg_q.key[191:128] <= cfg_data_i;
        actr_pkg::RegKey2:    cfg_q.key[127:64]  <= cfg_data_i;
        actr_pkg::RegKey3:    cfg_q.key[63:0]    <= cfg_data_i;
        actr_pkg::RegNonce:   cfg_q.nonce        <= cfg_data_i;
        actr_pkg::RegCtrInit: cfg_q.ctr_init     <= cfg_data_i;
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  // Front: accept, classify by block position, queue.
  actr_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .data_byte_i        (data_byte_i),
    .start_of_message_i (start_of_message_i),
    .end_of_message_i   (end_of_message_i),
    .pop_i              (pop),
    .entry_o            (entry),
    .status_o           (front_status)
  );

  // Back: build keystream blocks and emit transactions.
  actr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (front_status.valid),
    .entry_i     (entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .last_out_o  (last_out_o),
    .status_o    (back_status)
  );

  // The queue never holds more than its depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_status.count <= 2'(actr_pkg::QueueDepth))
    else $error("queue count beyond depth");

  // The back end only pops a queued entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_status.pop |-> front_status.valid)
    else $error("pop from empty queue");

  // While the back end works on an item, that item stays at the queue head.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_status.busy |-> front_status.valid)
    else $error("back end busy with no queued item");

endmodule
